// ===== rtl/mtwc_pkg.sv =====
// shared types, codes and constants for the triangle window cover block
`default_nettype none
package mtwc_pkg;

    localparam int MAX_LEGS_DEF   = 64;
    localparam int MAX_WINDOW_DEF = 256;
    localparam int COORD_W        = 32;
    localparam int OUT_LEN_W      = 9;

    // item operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WAYPT = 2'd1;
    localparam logic [1:0] OP_LINE  = 2'd2;

    // orientation sign codes
    localparam logic [1:0] ORI_ZERO = 2'd0;
    localparam logic [1:0] ORI_POS  = 2'd1;
    localparam logic [1:0] ORI_NEG  = 2'd2;

    // count sweep kinds
    localparam logic [1:0] SWK_EVICT = 2'd0;
    localparam logic [1:0] SWK_PUSH  = 2'd1;
    localparam logic [1:0] SWK_POP   = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ye;
    } line_t;

    typedef struct packed {
        logic path_clr;
        logic wp_wr;
        logic line_wr;
        logic wp_rd;
        logic diff_en;
        logic diff_pt;
        logic mul_en;
        logic mul_q;
        logic cmp_en;
        logic cmp_ref;
        logic ok_init;
        logic flag_wr;
        logic mask_new;
        logic ring_rd;
        logic ring_ld;
        logic push_ld;
        logic ovf_set;
        logic cnt_rd;
        logic cnt_wr;
        logic cnt_inc;
        logic pop_fin;
        logic push_fin;
        logic best_upd;
        logic out_ld;
    } cmd_t;

    typedef struct packed {
        logic line_last;
        logic size_full;
        logic size_nz;
        logic unc_zero;
        logic sweep_bit;
        logic out_busy;
    } stat_t;

endpackage
`default_nettype wire

// ===== rtl/mtwc_dp.sv =====
// datapath: lines, orientation unit, waypoint store, cover counts and window ring
`default_nettype none
module mtwc_dp #(
    parameter int MAX_LEGS   = mtwc_pkg::MAX_LEGS_DEF,
    parameter int MAX_WINDOW = mtwc_pkg::MAX_WINDOW_DEF
) (
    input  wire  logic                                     aclk,
    input  wire  logic                                     aresetn,
    input  wire  mtwc_pkg::cmd_t                           cmd,
    input  wire  logic [$clog2(MAX_LEGS+1)-1:0]            pt_addr,
    input  wire  logic [((MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1)-1:0] leg_idx,
    input  wire  logic signed [mtwc_pkg::COORD_W-1:0]      in_x_start,
    input  wire  logic signed [mtwc_pkg::COORD_W-1:0]      in_y_start,
    input  wire  logic signed [mtwc_pkg::COORD_W-1:0]      in_x_end,
    input  wire  logic signed [mtwc_pkg::COORD_W-1:0]      in_y_end,
    input  wire  logic                                     m_tready,
    output       mtwc_pkg::stat_t                          stat,
    output       logic [$clog2(MAX_LEGS+2)-1:0]            wp_count,
    output       logic                                     m_tvalid,
    output       logic [mtwc_pkg::OUT_LEN_W-1:0]           out_best,
    output       logic                                     out_found,
    output       logic [mtwc_pkg::OUT_LEN_W-1:0]           out_wlen,
    output       logic                                     out_ovf
);
    import mtwc_pkg::*;

    localparam int PCW = $clog2(MAX_LEGS+2);
    localparam int PAW = $clog2(MAX_LEGS+1);
    localparam int KW  = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;
    localparam int UW  = $clog2(MAX_LEGS+1);
    localparam int HW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW  = $clog2(MAX_WINDOW+1);
    localparam int TW  = SW + 1;

    function automatic logic signed [COORD_W:0] sx(input logic [COORD_W-1:0] v);
        return $signed({v[COORD_W-1], v});
    endfunction

    // line buffer and reference orientations, rotated so slot 0 is current
    line_t             ln_reg [3];
    logic [1:0]        lidx_reg;
    logic [1:0]        ref_reg [3];

    // waypoint store
    logic [2*COORD_W-1:0] wp_mem [MAX_LEGS+1];
    logic [2*COORD_W-1:0] wp_reg;
    logic [PCW-1:0]       wc_reg;

    // orientation unit
    logic signed [COORD_W:0]     d1_reg, d2_reg, d3_reg, d4_reg;
    logic signed [2*COORD_W+1:0] p_reg, q_reg, prod;
    logic signed [COORD_W:0]     mul_a, mul_b, cx, cy;
    logic [1:0]                  ori;
    logic                        ok_reg;
    logic [MAX_LEGS:0]           inflag_reg;

    // window and counts
    logic [MAX_LEGS-1:0] newmask_reg, sweep_reg, mask_c;
    logic [MAX_LEGS-1:0] ring_mem [MAX_WINDOW];
    logic [MAX_LEGS-1:0] ring_rd_reg;
    logic [SW-1:0]       cnt_mem [MAX_LEGS];
    logic [MAX_LEGS-1:0] cnt_vld_reg;
    logic [SW-1:0]       cnt_rd_reg;
    logic                cnt_rv_reg;
    logic [SW-1:0]       cnt_cur, cnt_nxt, cnt_wd;
    logic                cnt_we;
    logic [KW-1:0]       cnt_wa;
    logic [UW-1:0]       unc_reg;
    logic [HW-1:0]       head_reg, tail;
    logic [TW-1:0]       tail_sum;
    logic [SW-1:0]       size_reg, best_reg;
    logic                ovf_reg;
    logic [PCW-1:0]      legs;
    logic                wp_take;

    // output register
    logic                 m_valid_reg;
    logic [OUT_LEN_W-1:0] best_o_reg, wlen_o_reg;
    logic                 found_o_reg, ovf_o_reg;
    logic [31:0]          best_w, size_w;

    assign wp_take = cmd.wp_wr && (wc_reg < PCW'(MAX_LEGS+1));

    // line buffer shift, rotation and reference sign store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lidx_reg <= 2'd0;
        end else if (cmd.path_clr) begin
            lidx_reg <= 2'd0;
        end else if (cmd.line_wr) begin
            lidx_reg <= (lidx_reg == 2'd2) ? 2'd0 : lidx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.line_wr) begin
            ln_reg[0] <= ln_reg[1];
            ln_reg[1] <= ln_reg[2];
            ln_reg[2] <= '{xs: in_x_start, ys: in_y_start, xe: in_x_end, ye: in_y_end};
        end else if (cmd.cmp_en) begin
            ln_reg[0] <= ln_reg[1];
            ln_reg[1] <= ln_reg[2];
            ln_reg[2] <= ln_reg[0];
        end
        if (cmd.cmp_en) begin
            ref_reg[0] <= ref_reg[1];
            ref_reg[1] <= ref_reg[2];
            ref_reg[2] <= cmd.cmp_ref ? ori : ref_reg[0];
        end
    end

    // waypoint store and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg <= '0;
        end else if (cmd.path_clr) begin
            wc_reg <= '0;
        end else if (wp_take) begin
            wc_reg <= wc_reg + PCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wp_take) begin
            wp_mem[wc_reg[PAW-1:0]] <= {in_y_start, in_x_start};
        end
        if (cmd.wp_rd) begin
            wp_reg <= wp_mem[pt_addr];
        end
    end

    // orientation: differences, two products, compare
    assign cx    = cmd.diff_pt ? sx(wp_reg[COORD_W-1:0]) : sx(ln_reg[1].xs);
    assign cy    = cmd.diff_pt ? sx(wp_reg[2*COORD_W-1:COORD_W]) : sx(ln_reg[1].ys);
    assign mul_a = cmd.mul_q ? d3_reg : d1_reg;
    assign mul_b = cmd.mul_q ? d4_reg : d2_reg;
    assign prod  = mul_a * mul_b;

    always_comb begin
        if (p_reg > q_reg) begin
            ori = ORI_POS;
        end else if (p_reg < q_reg) begin
            ori = ORI_NEG;
        end else begin
            ori = ORI_ZERO;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.diff_en) begin
            d1_reg <= sx(ln_reg[0].xe) - sx(ln_reg[0].xs);
            d2_reg <= cy - sx(ln_reg[0].ys);
            d3_reg <= sx(ln_reg[0].ye) - sx(ln_reg[0].ys);
            d4_reg <= cx - sx(ln_reg[0].xs);
        end
        if (cmd.mul_en && !cmd.mul_q) begin
            p_reg <= prod;
        end
        if (cmd.mul_en && cmd.mul_q) begin
            q_reg <= prod;
        end
        if (cmd.ok_init) begin
            ok_reg <= 1'b1;
        end else if (cmd.cmp_en && !cmd.cmp_ref) begin
            ok_reg <= ok_reg && ((ori == ref_reg[0]) || (ori == ORI_ZERO));
        end
        if (cmd.flag_wr) begin
            inflag_reg[pt_addr] <= ok_reg;
        end
    end

    // leg mask from point flags
    assign legs = (wc_reg != '0) ? wc_reg - PCW'(1) : '0;
    always_comb begin
        for (int k = 0; k < MAX_LEGS; k++) begin
            mask_c[k] = inflag_reg[k] && inflag_reg[k+1] && (PCW'(k) < legs);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mask_new) begin
            newmask_reg <= mask_c;
        end
        if (cmd.ring_ld) begin
            sweep_reg <= ring_rd_reg;
        end else if (cmd.push_ld) begin
            sweep_reg <= newmask_reg;
        end
    end

    // window ring
    assign tail_sum = TW'(head_reg) + TW'(size_reg);
    assign tail = (tail_sum >= TW'(MAX_WINDOW)) ? HW'(tail_sum - TW'(MAX_WINDOW))
                                                : HW'(tail_sum);

    always_ff @(posedge aclk) begin
        if (cmd.push_fin) begin
            ring_mem[tail] <= newmask_reg;
        end
        if (cmd.ring_rd) begin
            ring_rd_reg <= ring_mem[head_reg];
        end
    end

    // cover count read-modify-write
    assign cnt_cur = cnt_rv_reg ? cnt_rd_reg : '0;
    always_comb begin
        if (cmd.cnt_inc) begin
            cnt_nxt = cnt_cur + SW'(1);
        end else if (cnt_cur != '0) begin
            cnt_nxt = cnt_cur - SW'(1);
        end else begin
            cnt_nxt = '0;
        end
        cnt_we = cmd.cnt_wr || (wp_take && (wc_reg != '0));
        cnt_wa = cmd.cnt_wr ? leg_idx : KW'(wc_reg - PCW'(1));
        cnt_wd = cmd.cnt_wr ? cnt_nxt : '0;
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.cnt_rd) begin
            cnt_rd_reg <= cnt_mem[leg_idx];
            cnt_rv_reg <= cnt_vld_reg[leg_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_vld_reg <= '0;
        end else if (cmd.path_clr) begin
            cnt_vld_reg <= '0;
        end else if (cnt_we) begin
            cnt_vld_reg[cnt_wa] <= 1'b1;
        end
    end

    // uncovered leg count, window pointers, best length, overflow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unc_reg  <= '0;
            head_reg <= '0;
            size_reg <= '0;
            best_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (cmd.path_clr) begin
            unc_reg  <= '0;
            head_reg <= '0;
            size_reg <= '0;
            best_reg <= '0;
        end else begin
            if (wp_take && (wc_reg != '0)) begin
                unc_reg <= unc_reg + UW'(1);
            end else if (cmd.cnt_wr && cmd.cnt_inc) begin
                if ((cnt_nxt == SW'(1)) && (unc_reg != '0)) begin
                    unc_reg <= unc_reg - UW'(1);
                end
            end else if (cmd.cnt_wr && (cnt_nxt == '0)) begin
                unc_reg <= unc_reg + UW'(1);
            end
            if (cmd.pop_fin) begin
                head_reg <= (head_reg == HW'(MAX_WINDOW-1)) ? '0 : head_reg + HW'(1);
                size_reg <= size_reg - SW'(1);
            end else if (cmd.push_fin) begin
                size_reg <= size_reg + SW'(1);
            end
            if (cmd.best_upd && ((best_reg == '0) || (size_reg < best_reg))) begin
                best_reg <= size_reg;
            end
            if (cmd.ovf_set) begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // output register
    assign best_w = 32'(best_reg);
    assign size_w = 32'(size_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_ld) begin
            best_o_reg  <= best_w[OUT_LEN_W-1:0];
            found_o_reg <= (best_reg != '0);
            wlen_o_reg  <= size_w[OUT_LEN_W-1:0];
            ovf_o_reg   <= ovf_reg;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign out_best  = best_o_reg;
    assign out_found = found_o_reg;
    assign out_wlen  = wlen_o_reg;
    assign out_ovf   = ovf_o_reg;
    assign wp_count  = wc_reg;

    assign stat.line_last = (lidx_reg == 2'd2);
    assign stat.size_full = (size_reg == SW'(MAX_WINDOW));
    assign stat.size_nz   = (size_reg != '0);
    assign stat.unc_zero  = (unc_reg == '0);
    assign stat.sweep_bit = sweep_reg[leg_idx];
    assign stat.out_busy  = m_valid_reg && !m_tready;

endmodule
`default_nettype wire

// ===== rtl/mtwc_ctrl.sv =====
// controller: sequences orientation tests, count sweeps and window shrinking
`default_nettype none
module mtwc_ctrl #(
    parameter int MAX_LEGS   = mtwc_pkg::MAX_LEGS_DEF,
    parameter int MAX_WINDOW = mtwc_pkg::MAX_WINDOW_DEF
) (
    input  wire  logic                            aclk,
    input  wire  logic                            aresetn,
    input  wire  logic                            s_tvalid,
    input  wire  logic [1:0]                      in_op,
    input  wire  mtwc_pkg::stat_t                 stat,
    input  wire  logic [$clog2(MAX_LEGS+2)-1:0]   wp_count,
    output       logic                            s_tready,
    output       mtwc_pkg::cmd_t                  cmd,
    output       logic [$clog2(MAX_LEGS+1)-1:0]   pt_addr,
    output       logic [((MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1)-1:0] leg_idx
);
    import mtwc_pkg::*;

    localparam int PCW = $clog2(MAX_LEGS+2);
    localparam int PAW = $clog2(MAX_LEGS+1);
    localparam int KW  = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DIFF   = 5'd1;
    localparam logic [4:0] S_MULP   = 5'd2;
    localparam logic [4:0] S_MULQ   = 5'd3;
    localparam logic [4:0] S_CMP    = 5'd4;
    localparam logic [4:0] S_PSTART = 5'd5;
    localparam logic [4:0] S_FLAG   = 5'd6;
    localparam logic [4:0] S_MASK   = 5'd7;
    localparam logic [4:0] S_EVRD   = 5'd8;
    localparam logic [4:0] S_RINGLD = 5'd9;
    localparam logic [4:0] S_PUSHLD = 5'd10;
    localparam logic [4:0] S_SWEEP  = 5'd11;
    localparam logic [4:0] S_SWWR   = 5'd12;
    localparam logic [4:0] S_SWEND  = 5'd13;
    localparam logic [4:0] S_LOOP   = 5'd14;
    localparam logic [4:0] S_OUT    = 5'd15;

    logic [4:0]     state_reg, state_next;
    logic [1:0]     li_reg, li_next;
    logic [PCW-1:0] pt_reg, pt_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [1:0]     kind_reg, kind_next;
    logic           refm_reg, refm_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            li_reg    <= 2'd0;
            pt_reg    <= '0;
            k_reg     <= '0;
            kind_reg  <= SWK_PUSH;
            refm_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            li_reg    <= li_next;
            pt_reg    <= pt_next;
            k_reg     <= k_next;
            kind_reg  <= kind_next;
            refm_reg  <= refm_next;
        end
    end

    assign pt_addr  = pt_reg[PAW-1:0];
    assign leg_idx  = k_reg;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        li_next    = li_reg;
        pt_next    = pt_reg;
        k_next     = k_reg;
        kind_next  = kind_reg;
        refm_next  = refm_reg;
        cmd        = '0;
        cmd.diff_pt = !refm_reg;
        cmd.cmp_ref = refm_reg;
        cmd.cnt_inc = (kind_reg == SWK_PUSH);
        case (state_reg)
            // take items; third line starts the triangle pass
            S_IDLE: begin
                if (s_tvalid) begin
                    case (in_op)
                        OP_CLEAR: cmd.path_clr = 1'b1;
                        OP_WAYPT: cmd.wp_wr = 1'b1;
                        OP_LINE: begin
                            cmd.line_wr = 1'b1;
                            if (stat.line_last) begin
                                state_next = S_DIFF;
                                refm_next  = 1'b1;
                                li_next    = 2'd0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // one orientation over four steps
            S_DIFF: begin
                cmd.diff_en = 1'b1;
                state_next  = S_MULP;
            end
            S_MULP: begin
                cmd.mul_en = 1'b1;
                state_next = S_MULQ;
            end
            S_MULQ: begin
                cmd.mul_en = 1'b1;
                cmd.mul_q  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.cmp_en = 1'b1;
                if (li_reg == 2'd2) begin
                    li_next = 2'd0;
                    if (refm_reg) begin
                        pt_next    = '0;
                        state_next = S_PSTART;
                    end else begin
                        state_next = S_FLAG;
                    end
                end else begin
                    li_next    = li_reg + 2'd1;
                    state_next = S_DIFF;
                end
            end
            // per waypoint inside test
            S_PSTART: begin
                if (pt_reg < wp_count) begin
                    cmd.wp_rd   = 1'b1;
                    cmd.ok_init = 1'b1;
                    refm_next   = 1'b0;
                    state_next  = S_DIFF;
                end else begin
                    state_next = S_MASK;
                end
            end
            S_FLAG: begin
                cmd.flag_wr = 1'b1;
                pt_next     = pt_reg + PCW'(1);
                state_next  = S_PSTART;
            end
            S_MASK: begin
                cmd.mask_new = 1'b1;
                state_next   = stat.size_full ? S_EVRD : S_PUSHLD;
            end
            // evict oldest entry of a full window
            S_EVRD: begin
                cmd.ring_rd = 1'b1;
                cmd.ovf_set = 1'b1;
                kind_next   = SWK_EVICT;
                state_next  = S_RINGLD;
            end
            S_RINGLD: begin
                cmd.ring_ld = 1'b1;
                k_next      = '0;
                state_next  = S_SWEEP;
            end
            S_PUSHLD: begin
                cmd.push_ld = 1'b1;
                kind_next   = SWK_PUSH;
                k_next      = '0;
                state_next  = S_SWEEP;
            end
            // walk all legs, update counts of marked ones
            S_SWEEP: begin
                if (stat.sweep_bit) begin
                    cmd.cnt_rd = 1'b1;
                    state_next = S_SWWR;
                end else if (k_reg == KW'(MAX_LEGS-1)) begin
                    state_next = S_SWEND;
                end else begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_SWWR: begin
                cmd.cnt_wr = 1'b1;
                if (k_reg == KW'(MAX_LEGS-1)) begin
                    state_next = S_SWEND;
                end else begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_SWEEP;
                end
            end
            S_SWEND: begin
                if (kind_reg == SWK_PUSH) begin
                    cmd.push_fin = 1'b1;
                    state_next   = S_LOOP;
                end else begin
                    cmd.pop_fin = 1'b1;
                    state_next  = (kind_reg == SWK_EVICT) ? S_PUSHLD : S_LOOP;
                end
            end
            // shrink from the front while every leg is covered
            S_LOOP: begin
                if (stat.unc_zero && stat.size_nz) begin
                    cmd.best_upd = 1'b1;
                    cmd.ring_rd  = 1'b1;
                    kind_next    = SWK_POP;
                    state_next   = S_RINGLD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/min_triangle_window_cover.sv =====
// top level of the triangle window cover block
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata coordinates
//  m_      | out | m_tvalid/m_tready  | m_tdata lengths and flags
//
// clear, waypoint and line items are taken while idle; the third line of a
// triangle starts a pass over the W waypoints and the S count sweeps (push,
// eviction, pops) of b marked legs, through the shared orientation multiplier
// and the cover count memory port.
// reset is synchronous; the result waits in an output register, so items are
// taken while it stalls until the next triangle finishes.
`default_nettype none
module min_triangle_window_cover #(
    parameter int MAX_LEGS   = mtwc_pkg::MAX_LEGS_DEF,
    parameter int MAX_WINDOW = mtwc_pkg::MAX_WINDOW_DEF
) (
    input  wire  logic         aclk,
    input  wire  logic         aresetn,
    input  wire  logic         s_tvalid,
    output       logic         s_tready,
    // [31:0] x_start, [63:32] y_start, [95:64] x_end, [127:96] y_end
    input  wire  logic [127:0] s_tdata,
    // [1:0] operation
    input  wire  logic [1:0]   s_tuser,
    output       logic         m_tvalid,
    input  wire  logic         m_tready,
    // [8:0] best_length, [9] found, [18:10] window_length, [19] overflow, rest zero
    output       logic [23:0]  m_tdata
);
    import mtwc_pkg::*;

    localparam int PCW = $clog2(MAX_LEGS+2);
    localparam int PAW = $clog2(MAX_LEGS+1);
    localparam int KW  = (MAX_LEGS > 1) ? $clog2(MAX_LEGS) : 1;

    cmd_t                 cmd;
    stat_t                stat;
    logic [PCW-1:0]       wp_count;
    logic [PAW-1:0]       pt_addr;
    logic [KW-1:0]        leg_idx;
    logic [OUT_LEN_W-1:0] out_best, out_wlen;
    logic                 out_found, out_ovf;
    logic                 s_rdy;

    assign s_tready = s_rdy;

    // sequencer
    mtwc_ctrl #(
        .MAX_LEGS   (MAX_LEGS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_op    (s_tuser),
        .stat     (stat),
        .wp_count (wp_count),
        .s_tready (s_rdy),
        .cmd      (cmd),
        .pt_addr  (pt_addr),
        .leg_idx  (leg_idx)
    );

    // datapath
    mtwc_dp #(
        .MAX_LEGS   (MAX_LEGS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .pt_addr    (pt_addr),
        .leg_idx    (leg_idx),
        .in_x_start (s_tdata[31:0]),
        .in_y_start (s_tdata[63:32]),
        .in_x_end   (s_tdata[95:64]),
        .in_y_end   (s_tdata[127:96]),
        .m_tready   (m_tready),
        .stat       (stat),
        .wp_count   (wp_count),
        .m_tvalid   (m_tvalid),
        .out_best   (out_best),
        .out_found  (out_found),
        .out_wlen   (out_wlen),
        .out_ovf    (out_ovf)
    );

    // result packing
    assign m_tdata = {4'd0, out_ovf, out_wlen, out_found, out_best};

endmodule
`default_nettype wire
